// ===== hw/rtl/pcal_pkg.sv =====
`default_nettype none

package pcal_pkg;

  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CNT_W     = 3;
  localparam logic [PIX_W-1:0] LEVEL_TOP = 8'd255;
  localparam logic [PIX_W-1:0] LEVEL_BOT = 8'd0;

  typedef enum logic {
    OP_GATHER = 1'b0,
    OP_APPLY  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // control from the sequencer to each channel divider
  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/per_channel_auto_level_top.sv =====
`default_nettype none

// per-channel auto level (min/max contrast stretch)
//
// input channel: in_valid / in_stall with op, frame_start, chan0..chan2.
//   op = gather: the pixel folds into the running per-channel min and max
//   in the beat's own cycle; frame_start restarts both from that pixel.
//   no output beat follows and the next beat may come in the next cycle.
//   op = apply: each channel is stretched as floor((p-min)*255/(max-min)),
//   flat or empty range passes through, values outside saturate.
// output channel: out_valid / out_stall with out0..out2, one beat per apply.
// divide: an apply beat is loaded into the three bit-serial dividers, whose
//   eight quotient steps end in the output register; in_stall is high
//   meanwhile, so no new beat is taken until the divide is done.
// the result sits in an output register, so a following beat is taken while
//   it waits; if the receiver stalls when a second result is done, the block
//   holds that result in the dividers and keeps in_stall high until the
//   output register frees up.
// reset: min resets to 255 and max to 0 in every channel, no beat pending.
module per_channel_auto_level_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       op,
  input  wire logic       frame_start,
  input  wire logic [7:0] chan0,
  input  wire logic [7:0] chan1,
  input  wire logic [7:0] chan2,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out0,
  output logic      [7:0] out1,
  output logic      [7:0] out2
);

  localparam int unsigned NC = pcal_pkg::NUM_CHAN;
  localparam int unsigned PW = pcal_pkg::PIX_W;
  localparam int unsigned CW = pcal_pkg::CNT_W;

  pcal_pkg::state_t   state;
  pcal_pkg::state_t   state_next;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_next;
  pcal_pkg::div_ctl_t div_ctl;

  logic                     in_take;
  logic                     out_free;
  logic                     out_load_run;
  logic                     out_load_hold;
  logic [NC-1:0][PW-1:0]    pix;
  logic [NC-1:0][PW-1:0]    lo;
  logic [NC-1:0][PW-1:0]    hi;
  logic [NC-1:0][PW-1:0]    q;
  logic [NC-1:0][PW-1:0]    q_next;

  assign pix      = {chan2, chan1, chan0};
  assign in_take  = in_valid && !in_stall;
  // output register can take a new result this cycle
  assign out_free = !out_valid || !out_stall;

  // running min / max
  pcal_stats u_stats (
    .clk         (clk),
    .rst         (rst),
    .upd         (in_take && (op == pcal_pkg::OP_GATHER)),
    .frame_start (frame_start),
    .pix         (pix),
    .lo          (lo),
    .hi          (hi)
  );

  // one divider per channel
  for (genvar c = 0; c < NC; c++) begin : g_div
    pcal_div u_div (
      .clk    (clk),
      .rst    (rst),
      .ctl    (div_ctl),
      .pix    (pix[c]),
      .lo     (lo[c]),
      .hi     (hi[c]),
      .q      (q[c]),
      .q_next (q_next[c])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      pcal_pkg::ST_IDLE: begin
        if (in_take && (op == pcal_pkg::OP_APPLY)) begin
          state_next = pcal_pkg::ST_RUN;
          cnt_next   = {CW{1'b1}};
        end
      end
      pcal_pkg::ST_RUN: begin
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = out_free ? pcal_pkg::ST_IDLE : pcal_pkg::ST_HOLD;
        end
      end
      pcal_pkg::ST_HOLD: begin
        if (out_free) state_next = pcal_pkg::ST_IDLE;
      end
      default: begin
        state_next = pcal_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall      = 1'b1;
    div_ctl       = '0;
    out_load_run  = 1'b0;
    out_load_hold = 1'b0;
    case (state)
      pcal_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        div_ctl.load = in_valid && (op == pcal_pkg::OP_APPLY);
      end
      pcal_pkg::ST_RUN: begin
        div_ctl.step = 1'b1;
        out_load_run = (cnt == '0) && out_free;
      end
      pcal_pkg::ST_HOLD: begin
        out_load_hold = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcal_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load_run || out_load_hold) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_run) begin
      out0 <= q_next[0];
      out1 <= q_next[1];
      out2 <= q_next[2];
    end else if (out_load_hold) begin
      out0 <= q[0];
      out1 <= q[1];
      out2 <= q[2];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pcal_stats.sv =====
`default_nettype none

module pcal_stats (
  input  wire logic                                                  clk,
  input  wire logic                                                  rst,
  input  wire logic                                                  upd,
  input  wire logic                                                  frame_start,
  input  wire logic [pcal_pkg::NUM_CHAN-1:0][pcal_pkg::PIX_W-1:0]    pix,
  output logic      [pcal_pkg::NUM_CHAN-1:0][pcal_pkg::PIX_W-1:0]    lo,
  output logic      [pcal_pkg::NUM_CHAN-1:0][pcal_pkg::PIX_W-1:0]    hi
);

  logic [pcal_pkg::NUM_CHAN-1:0][pcal_pkg::PIX_W-1:0] lo_next;
  logic [pcal_pkg::NUM_CHAN-1:0][pcal_pkg::PIX_W-1:0] hi_next;

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    for (int c = 0; c < pcal_pkg::NUM_CHAN; c++) begin
      if (upd) begin
        if (frame_start) begin
          lo_next[c] = pix[c];
          hi_next[c] = pix[c];
        end else begin
          if (pix[c] < lo[c]) lo_next[c] = pix[c];
          if (pix[c] > hi[c]) hi_next[c] = pix[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < pcal_pkg::NUM_CHAN; c++) begin
        lo[c] <= pcal_pkg::LEVEL_TOP;
        hi[c] <= pcal_pkg::LEVEL_BOT;
      end
    end else begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pcal_div.sv =====
`default_nettype none

// one channel: bit-serial restoring divide of (p-lo)*255 by (hi-lo)
module pcal_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire pcal_pkg::div_ctl_t         ctl,
  input  wire logic [pcal_pkg::PIX_W-1:0] pix,
  input  wire logic [pcal_pkg::PIX_W-1:0] lo,
  input  wire logic [pcal_pkg::PIX_W-1:0] hi,
  output logic      [pcal_pkg::PIX_W-1:0] q,
  output logic      [pcal_pkg::PIX_W-1:0] q_next
);

  localparam int unsigned W = pcal_pkg::PIX_W;

  logic           dividing;
  logic [W-1:0]   rem;
  logic [W-1:0]   num_lo;
  logic [W-1:0]   span;

  logic [W-1:0]   diff;
  logic [2*W-1:0] num;
  logic [W:0]     trial;
  logic [W:0]     trial_sub;
  logic           ge;

  // setup: numerator is diff*255 = (diff << 8) - diff
  assign diff = pix - lo;
  assign num  = {diff, {W{1'b0}}} - {{W{1'b0}}, diff};

  // one quotient bit per step
  assign trial     = {rem, num_lo[W-1]};
  assign trial_sub = trial - {1'b0, span};
  assign ge        = (trial >= {1'b0, span});
  assign q_next    = dividing ? {q[W-2:0], ge} : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      dividing <= 1'b0;
    end else if (ctl.load) begin
      dividing <= (hi > lo) && (pix > lo) && (pix < hi);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      span   <= hi - lo;
      rem    <= num[2*W-1:W];
      num_lo <= num[W-1:0];
      if (hi <= lo) begin
        q <= pix;
      end else if (pix <= lo) begin
        q <= pcal_pkg::LEVEL_BOT;
      end else if (pix >= hi) begin
        q <= pcal_pkg::LEVEL_TOP;
      end else begin
        q <= pcal_pkg::LEVEL_BOT;
      end
    end else if (ctl.step && dividing) begin
      rem    <= ge ? trial_sub[W-1:0] : trial[W-1:0];
      num_lo <= {num_lo[W-2:0], 1'b0};
      q      <= q_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pcal_chk.sv =====
`default_nettype none

module pcal_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       op,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out0,
  input wire logic [7:0] out1,
  input wire logic [7:0] out2
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out0) && $stable(out1) && $stable(out2))
    else $error("stalled output beat changed");

  // nothing pending right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // an apply beat keeps the input busy while dividing
  a_apply_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op |=> in_stall)
    else $error("apply beat did not block input");

  // a gather beat never blocks the input
  a_gather_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !op |=> !in_stall)
    else $error("gather beat blocked input");

  // a new result only appears at the end of a divide
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a divide");

endmodule

bind per_channel_auto_level_top pcal_chk u_pcal_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .op        (op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out0      (out0),
  .out1      (out1),
  .out2      (out2)
);

`default_nettype wire
